// File: src/mma_pkg.sv
// Shared types, operation codes and fp32 helpers for the matrix multiply-accumulate block.
package mma_pkg;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_LOAD_C  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [1:0] CFG_COLS_N  = 2'd1;
    localparam logic [1:0] CFG_INNER_K = 2'd2;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } mma_in_t;

    typedef struct packed {
        logic [5:0]  out_row;
        logic [5:0]  out_col;
        logic [31:0] out_value;
    } mma_out_t;

    typedef struct packed {
        logic        start;
        logic        op_add;
        logic [31:0] opa;
        logic [31:0] opb;
    } mma_fpu_req_t;

    function automatic logic [5:0] lzc48(input logic [47:0] m);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (m[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] canon_nan(input logic [31:0] v);
        logic [31:0] r;
        r = v;
        if (v[30:23] == 8'hFF && v[22:0] != 23'd0) begin
            r = CANON_NAN;
        end
        return r;
    endfunction

endpackage

// File: src/mma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/mma_fpu.sv
// Five-stage fp32 multiply or add unit with shared normalize and round-to-nearest-even.
module mma_fpu
    import mma_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  mma_fpu_req_t req,
    output logic         done,
    output logic [31:0]  result
);

    logic        sa, sb;
    logic [7:0]  ea, eb, eae, ebe;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic        a_big;
    logic [23:0] big_m, sm_m;
    logic [7:0]  big_e, sm_e, d;
    logic [26:0] sm27, sh27;
    logic        lost;
    logic        spec_c;
    logic [31:0] specv_c;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [47:0]        s1_prod_reg;
    logic [26:0]        s1_big_reg, s1_small_reg;
    logic               s1_sub_reg, s1_sign_reg, s1_zsign_reg, s1_add_reg;
    logic signed [11:0] s1_exp_reg;
    logic               s1_spec_reg, s2_spec_reg, s3_spec_reg, s4_spec_reg;
    logic [31:0]        s1_specv_reg, s2_specv_reg, s3_specv_reg, s4_specv_reg;

    logic [27:0]        sum28;
    logic [47:0]        s2_m_reg, s3_m_reg;
    logic signed [11:0] s2_exp_reg, s3_e_reg;
    logic               s2_sign_reg, s3_sign_reg, s4_sign_reg;
    logic [5:0]         s3_lz_reg;
    logic               s3_zero_reg, s4_zero_reg;

    logic [5:0]         lz;
    logic [47:0]        n48;
    logic [7:0]         ef;
    logic signed [11:0] sh, rs;
    logic [47:0]        s4_n_reg;
    logic [7:0]         s4_ef_reg;
    logic               s4_ovf_reg;

    logic [30:0]        base, rounded;
    logic               rnd;
    logic [31:0]        result_reg;

    always_comb begin
        sa     = req.opa[31];
        sb     = req.opb[31];
        ea     = req.opa[30:23];
        eb     = req.opb[30:23];
        ma     = {ea != 8'd0, req.opa[22:0]};
        mb     = {eb != 8'd0, req.opb[22:0]};
        eae    = (ea == 8'd0) ? 8'd1 : ea;
        ebe    = (eb == 8'd0) ? 8'd1 : eb;
        nan_a  = (ea == 8'hFF) && (req.opa[22:0] != 23'd0);
        nan_b  = (eb == 8'hFF) && (req.opb[22:0] != 23'd0);
        inf_a  = (ea == 8'hFF) && (req.opa[22:0] == 23'd0);
        inf_b  = (eb == 8'hFF) && (req.opb[22:0] == 23'd0);
        zero_a = req.opa[30:0] == 31'd0;
        zero_b = req.opb[30:0] == 31'd0;

        a_big = req.opa[30:0] >= req.opb[30:0];
        big_m = a_big ? ma : mb;
        sm_m  = a_big ? mb : ma;
        big_e = a_big ? eae : ebe;
        sm_e  = a_big ? ebe : eae;
        d     = big_e - sm_e;
        sm27  = {sm_m, 3'b000};
        if (d >= 8'd27) begin
            sh27 = '0;
            lost = |sm27;
        end else begin
            sh27 = sm27 >> d;
            lost = |(sm27 & ~({27{1'b1}} << d));
        end
        sh27 = sh27 | 27'(lost);

        if (req.op_add) begin
            spec_c  = nan_a || nan_b || inf_a || inf_b;
            if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
                specv_c = CANON_NAN;
            end else if (inf_a) begin
                specv_c = {sa, 8'hFF, 23'd0};
            end else begin
                specv_c = {sb, 8'hFF, 23'd0};
            end
        end else begin
            spec_c = nan_a || nan_b || inf_a || inf_b;
            if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
                specv_c = CANON_NAN;
            end else begin
                specv_c = {sa ^ sb, 8'hFF, 23'd0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_prod_reg  <= ma * mb;
        s1_big_reg   <= {big_m, 3'b000};
        s1_small_reg <= sh27;
        s1_sub_reg   <= sa ^ sb;
        s1_zsign_reg <= sa & sb;
        s1_add_reg   <= req.op_add;
        s1_spec_reg  <= spec_c;
        s1_specv_reg <= specv_c;
        if (req.op_add) begin
            s1_exp_reg  <= $signed({4'd0, big_e});
            s1_sign_reg <= a_big ? sa : sb;
        end else begin
            s1_exp_reg  <= $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd127;
            s1_sign_reg <= sa ^ sb;
        end
    end

    assign sum28 = s1_sub_reg ? ({1'b0, s1_big_reg} - {1'b0, s1_small_reg})
                              : ({1'b0, s1_big_reg} + {1'b0, s1_small_reg});

    always_ff @(posedge aclk) begin
        s2_m_reg     <= s1_add_reg ? {sum28, 20'd0} : s1_prod_reg;
        s2_exp_reg   <= s1_exp_reg;
        s2_sign_reg  <= (s1_add_reg && sum28 == 28'd0) ? s1_zsign_reg : s1_sign_reg;
        s2_spec_reg  <= s1_spec_reg;
        s2_specv_reg <= s1_specv_reg;
    end

    assign lz = lzc48(s2_m_reg);

    always_ff @(posedge aclk) begin
        s3_m_reg     <= s2_m_reg;
        s3_lz_reg    <= lz;
        s3_e_reg     <= s2_exp_reg + 12'sd1 - $signed({6'd0, lz});
        s3_zero_reg  <= s2_m_reg == 48'd0;
        s3_sign_reg  <= s2_sign_reg;
        s3_spec_reg  <= s2_spec_reg;
        s3_specv_reg <= s2_specv_reg;
    end

    always_comb begin
        sh = s3_e_reg + $signed({6'd0, s3_lz_reg}) - 12'sd1;
        rs = -sh;
        if (s3_e_reg >= 12'sd1) begin
            n48 = s3_m_reg << s3_lz_reg;
            ef  = s3_e_reg[7:0];
        end else begin
            ef = 8'd0;
            if (sh >= 12'sd0) begin
                n48 = s3_m_reg << sh[5:0];
            end else if (rs >= 12'sd48) begin
                n48 = 48'(|s3_m_reg);
            end else begin
                n48 = (s3_m_reg >> rs[5:0])
                    | 48'(|(s3_m_reg & ~({48{1'b1}} << rs[5:0])));
            end
        end
    end

    always_ff @(posedge aclk) begin
        s4_n_reg     <= n48;
        s4_ef_reg    <= ef;
        s4_ovf_reg   <= s3_e_reg >= 12'sd255;
        s4_zero_reg  <= s3_zero_reg;
        s4_sign_reg  <= s3_sign_reg;
        s4_spec_reg  <= s3_spec_reg;
        s4_specv_reg <= s3_specv_reg;
    end

    always_comb begin
        base    = {s4_ef_reg, s4_n_reg[46:24]};
        rnd     = s4_n_reg[23] && ((|s4_n_reg[22:0]) || s4_n_reg[24]);
        rounded = base + 31'(rnd);
    end

    always_ff @(posedge aclk) begin
        if (s4_spec_reg) begin
            result_reg <= s4_specv_reg;
        end else if (s4_zero_reg) begin
            result_reg <= {s4_sign_reg, 31'd0};
        end else if (s4_ovf_reg) begin
            result_reg <= {s4_sign_reg, 8'hFF, 23'd0};
        end else begin
            result_reg <= {s4_sign_reg, rounded};
        end
    end

    assign done   = v5_reg;
    assign result = result_reg;

endmodule

// File: src/fp32_matrix_multiply_accumulate.sv
// Top level: matrix stores, element sequencer and output register of the fp32 multiply-accumulate.
// Load words are accepted back to back while the sequencer is idle.
// A compute word reads its C element, then for each of min(inner_k, MAX_INNER) inner
// terms takes a RAM read state, an operand state and two passes through the shared
// fp unit (multiply, then add) before its result word is registered.
// Throughput is one word at a time; the result register frees the output side.
// Synchronous active-low reset clears control and size registers (sizes to 64);
// matrix contents are not cleared.
module fp32_matrix_multiply_accumulate
    import mma_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int MAX_INNER = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  mma_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output mma_out_t   m_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_wdata
);

    localparam int DA   = MAX_ROWS * MAX_INNER;
    localparam int DB   = MAX_INNER * MAX_COLS;
    localparam int DC   = MAX_ROWS * MAX_COLS;
    localparam int AW_A = (DA > 1) ? $clog2(DA) : 1;
    localparam int AW_B = (DB > 1) ? $clog2(DB) : 1;
    localparam int AW_C = (DC > 1) ? $clog2(DC) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CRD    = 3'd1;
    localparam logic [2:0] S_ABWAIT = 3'd2;
    localparam logic [2:0] S_ABDATA = 3'd3;
    localparam logic [2:0] S_MULW   = 3'd4;
    localparam logic [2:0] S_ADDW   = 3'd5;
    localparam logic [2:0] S_WB     = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  rows_m_reg, cols_n_reg, inner_k_reg;
    logic [5:0]  r_reg, r_next, c_reg, c_next;
    logic [6:0]  t_reg, t_next, t_inc;
    logic [31:0] acc_reg, acc_next;
    logic        m_valid_reg, m_valid_next;
    mma_out_t    m_data_reg, m_data_next;

    logic        accept, row_in_m, row_in_k, col_in_n, col_in_k, more;
    logic        a_we, b_we, c_we;
    logic [AW_A-1:0] a_waddr, a_raddr;
    logic [AW_B-1:0] b_waddr, b_raddr;
    logic [AW_C-1:0] c_waddr, c_raddr;
    logic [31:0] c_wdata, a_rdata, b_rdata, c_rdata;
    logic        out_free;

    mma_fpu_req_t fpu_req;
    logic         fpu_done;
    logic [31:0]  fpu_result;

    assign accept   = s_valid && s_ready;
    assign s_ready  = state_reg == S_IDLE;
    assign out_free = !m_valid_reg || m_ready;

    assign row_in_m = ({1'b0, s_data.row} < rows_m_reg) && (32'(s_data.row) < 32'(MAX_ROWS));
    assign row_in_k = ({1'b0, s_data.row} < inner_k_reg) && (32'(s_data.row) < 32'(MAX_INNER));
    assign col_in_n = ({1'b0, s_data.col} < cols_n_reg) && (32'(s_data.col) < 32'(MAX_COLS));
    assign col_in_k = ({1'b0, s_data.col} < inner_k_reg) && (32'(s_data.col) < 32'(MAX_INNER));

    assign t_inc = t_reg + 7'd1;
    assign more  = (t_inc < inner_k_reg) && (32'(t_inc) < 32'(MAX_INNER));

    assign a_waddr = AW_A'(s_data.row) * AW_A'(MAX_INNER) + AW_A'(s_data.col);
    assign b_waddr = AW_B'(s_data.row) * AW_B'(MAX_COLS) + AW_B'(s_data.col);
    assign a_raddr = AW_A'(r_reg) * AW_A'(MAX_INNER) + AW_A'(t_reg);
    assign b_raddr = AW_B'(t_reg) * AW_B'(MAX_COLS) + AW_B'(c_reg);
    assign c_raddr = AW_C'(s_data.row) * AW_C'(MAX_COLS) + AW_C'(s_data.col);

    always_comb begin
        a_we = accept && s_data.operation == OP_LOAD_A && row_in_m && col_in_k;
        b_we = accept && s_data.operation == OP_LOAD_B && row_in_k && col_in_n;
        if (state_reg == S_WB) begin
            c_we    = out_free;
            c_waddr = AW_C'(r_reg) * AW_C'(MAX_COLS) + AW_C'(c_reg);
            c_wdata = canon_nan(acc_reg);
        end else begin
            c_we    = accept && s_data.operation == OP_LOAD_C && row_in_m && col_in_n;
            c_waddr = c_raddr;
            c_wdata = s_data.value;
        end
    end

    mma_ram #(.WIDTH(32), .DEPTH(DA)) u_ram_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (s_data.value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mma_ram #(.WIDTH(32), .DEPTH(DB)) u_ram_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (s_data.value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mma_ram #(.WIDTH(32), .DEPTH(DC)) u_ram_c (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_comb begin
        fpu_req.start  = (state_reg == S_ABDATA) || (state_reg == S_MULW && fpu_done);
        fpu_req.op_add = state_reg == S_MULW;
        fpu_req.opa    = (state_reg == S_MULW) ? acc_reg : a_rdata;
        fpu_req.opb    = (state_reg == S_MULW) ? fpu_result : b_rdata;
    end

    mma_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .done    (fpu_done),
        .result  (fpu_result)
    );

    always_comb begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_data.operation == OP_COMPUTE && row_in_m && col_in_n) begin
                    r_next     = s_data.row;
                    c_next     = s_data.col;
                    state_next = S_CRD;
                end
            end
            S_CRD: begin
                acc_next   = c_rdata;
                t_next     = 7'd0;
                state_next = (inner_k_reg != 7'd0) ? S_ABWAIT : S_WB;
            end
            S_ABWAIT: begin
                state_next = S_ABDATA;
            end
            S_ABDATA: begin
                state_next = S_MULW;
            end
            S_MULW: begin
                if (fpu_done) begin
                    state_next = S_ADDW;
                end
            end
            S_ADDW: begin
                if (fpu_done) begin
                    acc_next   = fpu_result;
                    t_next     = t_inc;
                    state_next = more ? S_ABWAIT : S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_row   = r_reg;
                    m_data_next.out_col   = c_reg;
                    m_data_next.out_value = canon_nan(acc_reg);
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rows_m_reg  <= 7'd64;
            cols_n_reg  <= 7'd64;
            inner_k_reg <= 7'd64;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ROWS_M:  rows_m_reg  <= cfg_wdata;
                    CFG_COLS_N:  cols_n_reg  <= cfg_wdata;
                    CFG_INNER_K: inner_k_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_fpu_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_done |-> (state_reg == S_MULW || state_reg == S_ADDW))
        else $error("fp unit result outside a wait state");

    a_compute_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.operation == OP_COMPUTE && row_in_m && col_in_n) |=> !s_ready)
        else $error("compute word did not start the sequencer");

    a_wb_keeps_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WB && !out_free) |=> (state_reg == S_WB && m_valid_reg))
        else $error("write-back overran a pending result");

    a_term_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ABDATA) |-> (t_reg < inner_k_reg && 32'(t_reg) < 32'(MAX_INNER)))
        else $error("inner index out of range");

endmodule
